[src/chs_pkg.sv]
// Shared types, widths and constants for the compass heading CORDIC pipeline.
// No dependencies; used by every module under src/.
package chs_pkg;

   localparam int IN_W             = 16;  // input count width
   localparam int PRE_SHIFT        = 16;  // counts are scaled up by 2^16 before rotation
   localparam int VEC_W            = 36;  // vector path, covers CORDIC gain with margin
   localparam int ANG_BITS         = 20;  // angle fraction bits (2^-20 degree)
   localparam int ANG_W            = 30;  // signed angle accumulator width
   localparam int TABLE_LEN        = 24;  // arctangent table entries
   localparam int FRAC_BITS        = 6;   // heading fraction bits
   localparam int HEAD_W           = 15;  // heading output width
   localparam int CORDIC_STEPS_DEF = 16;  // default number of micro-rotations

   localparam logic [ANG_W-1:0] DEG180    = ANG_W'(180 * (2 ** ANG_BITS));
   localparam logic [ANG_W-1:0] DEG360    = ANG_W'(360 * (2 ** ANG_BITS));
   localparam logic [ANG_W-1:0] ROUND_ADD = ANG_W'(2 ** (ANG_BITS - FRAC_BITS - 1));
   localparam logic [ANG_W-1:0] FULL_TURN = ANG_W'(360 * (2 ** FRAC_BITS));

   // One word in flight through the rotation stages
   typedef struct packed {
      logic signed [VEC_W-1:0] a;
      logic signed [VEC_W-1:0] b;
      logic signed [ANG_W-1:0] z;
      logic                    zero;
   } cordic_word_type;

   // atan(2^-idx) in degrees, rounded to 2^-20 degree
   function automatic logic [ANG_W-1:0] atan_entry(input int idx);
      logic [ANG_W-1:0] val;
      case (idx)
         0:       val = ANG_W'(47185920);
         1:       val = ANG_W'(27855475);
         2:       val = ANG_W'(14718068);
         3:       val = ANG_W'(7471121);
         4:       val = ANG_W'(3750058);
         5:       val = ANG_W'(1876857);
         6:       val = ANG_W'(938658);
         7:       val = ANG_W'(469357);
         8:       val = ANG_W'(234682);
         9:       val = ANG_W'(117342);
         10:      val = ANG_W'(58671);
         11:      val = ANG_W'(29335);
         12:      val = ANG_W'(14668);
         13:      val = ANG_W'(7334);
         14:      val = ANG_W'(3667);
         15:      val = ANG_W'(1833);
         16:      val = ANG_W'(917);
         17:      val = ANG_W'(458);
         18:      val = ANG_W'(229);
         19:      val = ANG_W'(115);
         20:      val = ANG_W'(57);
         21:      val = ANG_W'(29);
         22:      val = ANG_W'(14);
         23:      val = ANG_W'(7);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[src/chs_prerot.sv]
// Entry stage: scales the counts, forms -Y at 17 bits and folds the left half-plane
// onto the right half-plane. Depends on chs_pkg.
module chs_prerot (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [chs_pkg::IN_W-1:0]     x_count,
   input  logic signed [chs_pkg::IN_W-1:0]     y_count,
   output logic                                out_valid,
   input  logic                                out_ready,
   output chs_pkg::cordic_word_type            out_word
);

   logic                          valid_ff;
   chs_pkg::cordic_word_type      word_ff;
   chs_pkg::cordic_word_type      word_in;

   logic signed [chs_pkg::IN_W:0] x_ext;
   logic signed [chs_pkg::IN_W:0] y_ext;
   logic signed [chs_pkg::IN_W:0] mag_x;
   logic signed [chs_pkg::IN_W:0] b_src;

   // 17-bit forms so that negating -32768 is exact
   always_comb begin
      x_ext = {x_count[chs_pkg::IN_W-1], x_count};
      y_ext = {y_count[chs_pkg::IN_W-1], y_count};
      if (x_count[chs_pkg::IN_W-1]) begin
         mag_x     = -x_ext;
         b_src     = y_ext;
         word_in.z = chs_pkg::DEG180;
      end else begin
         mag_x     = x_ext;
         b_src     = -y_ext;
         word_in.z = '0;
      end
      word_in.a    = chs_pkg::VEC_W'(mag_x) <<< chs_pkg::PRE_SHIFT;
      word_in.b    = chs_pkg::VEC_W'(b_src) <<< chs_pkg::PRE_SHIFT;
      word_in.zero = (x_count == '0) && (y_count == '0);
   end

   // Stage register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

[src/chs_cordic_stage.sv]
// One vectoring micro-rotation of the CORDIC, registered.
// Depends on chs_pkg for the word type and the arctangent table.
module chs_cordic_stage #(
   parameter int STEP = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  chs_pkg::cordic_word_type in_word,
   output logic                     out_valid,
   input  logic                     out_ready,
   output chs_pkg::cordic_word_type out_word
);

   localparam logic signed [chs_pkg::ANG_W-1:0] ANGLE = chs_pkg::atan_entry(STEP);

   logic                                 valid_ff;
   chs_pkg::cordic_word_type             word_ff;
   chs_pkg::cordic_word_type             word_in;
   logic signed [chs_pkg::VEC_W-1:0]     da;
   logic signed [chs_pkg::VEC_W-1:0]     db;

   // Rotate toward b = 0; floor shifts on both legs
   always_comb begin
      da           = in_word.b >>> STEP;
      db           = in_word.a >>> STEP;
      word_in.zero = in_word.zero;
      if (!in_word.b[chs_pkg::VEC_W-1]) begin
         word_in.a = in_word.a + da;
         word_in.b = in_word.b - db;
         word_in.z = in_word.z + ANGLE;
      end else begin
         word_in.a = in_word.a - da;
         word_in.b = in_word.b + db;
         word_in.z = in_word.z - ANGLE;
      end
   end

   // Stage register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

[src/chs_finish.sv]
// Output stage: wraps the angle into [0, 360), rounds to the heading grid,
// folds a full turn to zero and forces zero for a null vector. Depends on chs_pkg.
module chs_finish (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  chs_pkg::cordic_word_type          in_word,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [chs_pkg::HEAD_W-1:0]        heading_q6,
   output logic                              zero_field
);

   logic                            valid_ff;
   logic [chs_pkg::HEAD_W-1:0]      heading_ff;
   logic [chs_pkg::HEAD_W-1:0]      heading_in;
   logic                            zero_ff;
   logic [chs_pkg::ANG_W-1:0]       offset;
   logic [chs_pkg::ANG_W-1:0]       sum;
   logic [chs_pkg::ANG_W-1:0]       q;
   logic [chs_pkg::ANG_W-1:0]       q_wrap;

   // Wrap and rounding offset merged into one add
   always_comb begin
      if (in_word.z[chs_pkg::ANG_W-1]) begin
         offset = chs_pkg::DEG360 + chs_pkg::ROUND_ADD;
      end else begin
         offset = chs_pkg::ROUND_ADD;
      end
      sum = in_word.z + offset;
      q   = sum >> (chs_pkg::ANG_BITS - chs_pkg::FRAC_BITS);
      if (q >= chs_pkg::FULL_TURN) begin
         q_wrap = q - chs_pkg::FULL_TURN;
      end else begin
         q_wrap = q;
      end
      heading_in = in_word.zero ? '0 : q_wrap[chs_pkg::HEAD_W-1:0];
   end

   // Output register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         heading_ff <= heading_in;
         zero_ff    <= in_word.zero;
      end
   end

   assign out_valid  = valid_ff;
   assign heading_q6 = heading_ff;
   assign zero_field = zero_ff;

endmodule

[src/compass_heading_atan2.sv]
// Compass heading from a pair of magnetometer counts: atan2(-Y, X) in 1/64 degree.
// Depends on chs_pkg, chs_prerot, chs_cordic_stage and chs_finish.
//
// Use:
//   req channel: one word per accepted handshake, signed X and Y counts.
//   rsp channel: heading in [0, 360) degrees as an unsigned count of 1/64 degree,
//   rounded to nearest; zero_field is set (and heading is 0) for a null vector.
//   Words come out in the order they went in, one result per request.
// Path: the accepted word is registered in the entry stage, then in one register
//   per micro-rotation (steps capped at 24), then in the output stage.
// Throughput: one word per cycle while rsp_ready is high; each micro-rotation has
//   its own adder stage.
// Stall: every stage has its own valid bit and holds its word while the next stage
//   is full, so a held rsp_ready fills empty stages first and only then drops
//   req_ready. Nothing is lost or repeated.
// Reset: synchronous, active high; clears all valid bits, the pipeline comes up
//   empty and ready.
module compass_heading_atan2 #(
   parameter int CORDIC_STEPS = chs_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [chs_pkg::IN_W-1:0]     req_x_count,
   input  logic signed [chs_pkg::IN_W-1:0]     req_y_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [chs_pkg::HEAD_W-1:0]          rsp_heading_q6,
   output logic                                rsp_zero_field
);

   // The table bounds the number of micro-rotations
   localparam int STAGES = (CORDIC_STEPS < chs_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                               : chs_pkg::TABLE_LEN;

   chs_pkg::cordic_word_type stg_word [0:STAGES];
   logic [STAGES:0]          stg_valid;
   logic [STAGES:0]          stg_ready;

   // Half-plane fold
   chs_prerot u_prerot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .x_count   (req_x_count),
      .y_count   (req_y_count),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_word  (stg_word[0])
   );

   // Micro-rotation chain
   for (genvar k = 0; k < STAGES; k++) begin : g_rot
      chs_cordic_stage #(
         .STEP (k)
      ) u_rot (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_word   (stg_word[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_word  (stg_word[k+1])
      );
   end

   // Wrap, round, output register
   chs_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (stg_valid[STAGES]),
      .in_ready   (stg_ready[STAGES]),
      .in_word    (stg_word[STAGES]),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .heading_q6 (rsp_heading_q6),
      .zero_field (rsp_zero_field)
   );

endmodule

[src/chs_checker.sv]
// Port-level checks for compass_heading_atan2, attached by the bind below.
// Depends on chs_pkg and on the top level's port list.
module chs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [chs_pkg::IN_W-1:0]        req_x_count,
   input logic [chs_pkg::IN_W-1:0]        req_y_count,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [chs_pkg::HEAD_W-1:0]      rsp_heading_q6,
   input logic                            rsp_zero_field
);

   // Pipeline comes up empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

   // A waiting request word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_x_count)
                                  && $stable(req_y_count))
      else $error("waiting request word changed");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_heading_q6)
                                  && $stable(rsp_zero_field))
      else $error("stalled result word changed");

   // Null vector reads as heading zero
   a_zero_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_field |-> rsp_heading_q6 == '0)
      else $error("zero_field set with nonzero heading");

   // A draining output never back-pressures the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low while rsp_ready high");

endmodule

bind compass_heading_atan2 chs_checker u_chs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_x_count    (req_x_count),
   .req_y_count    (req_y_count),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_heading_q6 (rsp_heading_q6),
   .rsp_zero_field (rsp_zero_field)
);

[tb/heading_checker.sv]
// Scoreboard for compass_heading_atan2: watches both channels, predicts each heading
// with its own CORDIC in 64-bit integers and compares every response word in order.
// Depends on chs_pkg for widths and the fixed-point constants.
module heading_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [chs_pkg::IN_W-1:0]   req_x_count,
   input  logic signed [chs_pkg::IN_W-1:0]   req_y_count,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [chs_pkg::HEAD_W-1:0]        rsp_heading_q6,
   input  logic                              rsp_zero_field,
   output int                                mismatches,
   output int                                words_pending,
   output int                                words_checked
);

   localparam int IN_W      = chs_pkg::IN_W;
   localparam int HEAD_W    = chs_pkg::HEAD_W;
   localparam int ANG_BITS  = chs_pkg::ANG_BITS;
   localparam int FRAC_BITS = chs_pkg::FRAC_BITS;

   typedef struct {
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic [HEAD_W-1:0]      heading;
      logic                   zero_field;
   } heading_pred_type;

   heading_pred_type expected_headings[$];
   int err_count;
   int checked_count;

   // atan(2^-k) in degrees, Q20
   function automatic longint atan_step_q20(input int k);
      case (k)
         0:       return 47185920;
         1:       return 27855475;
         2:       return 14718068;
         3:       return 7471121;
         4:       return 3750058;
         5:       return 1876857;
         6:       return 938658;
         7:       return 469357;
         8:       return 234682;
         9:       return 117342;
         10:      return 58671;
         11:      return 29335;
         12:      return 14668;
         13:      return 7334;
         14:      return 3667;
         15:      return 1833;
         16:      return 917;
         17:      return 458;
         18:      return 229;
         19:      return 115;
         20:      return 57;
         21:      return 29;
         22:      return 14;
         default: return 7;
      endcase
   endfunction

   // Vectoring CORDIC on (x, -y); heading in 1/64 degree, wrapped into one turn
   function automatic heading_pred_type predict_heading(input logic signed [IN_W-1:0] x,
                                                        input logic signed [IN_W-1:0] y);
      heading_pred_type e;
      longint a, b, z, da, db, q;
      e.x = x;
      e.y = y;
      e.heading = '0;
      e.zero_field = 1'b0;
      if (x == 0 && y == 0) begin
         e.zero_field = 1'b1;
         return e;
      end
      a = longint'(x) * 65536;
      b = -longint'(y) * 65536;
      z = 0;
      // left half-plane: turn by 180 first
      if (a < 0) begin
         a = -a;
         b = -b;
         z = longint'(180) <<< ANG_BITS;
      end
      for (int k = 0; k < chs_pkg::CORDIC_STEPS_DEF && k < chs_pkg::TABLE_LEN; k++) begin
         da = b >>> k;
         db = a >>> k;
         if (b >= 0) begin
            a = a + da;
            b = b - db;
            z = z + atan_step_q20(k);
         end else begin
            a = a - da;
            b = b + db;
            z = z - atan_step_q20(k);
         end
      end
      if (z < 0) z = z + (longint'(360) <<< ANG_BITS);
      q = (z + (longint'(1) <<< (ANG_BITS - FRAC_BITS - 1))) >>> (ANG_BITS - FRAC_BITS);
      // rounding up to a full turn reads as north
      if (q >= (longint'(360) <<< FRAC_BITS)) q = q - (longint'(360) <<< FRAC_BITS);
      e.heading = q[HEAD_W-1:0];
      return e;
   endfunction

   // Compare leaving words first, then record the entering word
   always @(posedge clock) begin
      heading_pred_type e;
      if (reset) begin
         expected_headings.delete();
         err_count = 0;
         checked_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_headings.size() == 0) begin
               $display("%0t unexpected response word: heading %0d zero_field %0b",
                        $time, rsp_heading_q6, rsp_zero_field);
               err_count++;
            end else begin
               e = expected_headings.pop_front();
               checked_count++;
               if (rsp_heading_q6 !== e.heading) begin
                  $display("%0t heading mismatch (x=%0d y=%0d): expected %0d, got %0d",
                           $time, e.x, e.y, e.heading, rsp_heading_q6);
                  err_count++;
               end
               if (rsp_zero_field !== e.zero_field) begin
                  $display("%0t zero_field mismatch (x=%0d y=%0d): expected %0b, got %0b",
                           $time, e.x, e.y, e.zero_field, rsp_zero_field);
                  err_count++;
               end
            end
         end
         if (req_valid && req_ready) expected_headings.push_back(
            predict_heading(req_x_count, req_y_count));
      end
      mismatches    <= err_count;
      words_checked <= checked_count;
      words_pending <= expected_headings.size();
   end

endmodule

[tb/tb.sv]
// Top of the compass_heading_atan2 bench: clock, reset, request and response traffic.
// Depends on chs_pkg, the block under src/ and heading_checker; prints the verdict.
module tb;

   localparam int RANDOM_WORDS = 1800;
   localparam int HOLD_CYCLES  = 200;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int IN_W         = chs_pkg::IN_W;
   localparam int HEAD_W       = chs_pkg::HEAD_W;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic signed [IN_W-1:0] req_x_count;
   logic signed [IN_W-1:0] req_y_count;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [HEAD_W-1:0]      rsp_heading_q6;
   logic                   rsp_zero_field;

   int mismatches;
   int words_pending;
   int words_checked;
   int words_sent = 0;
   int directed_words = 0;
   int cycle_count = 0;

   compass_heading_atan2 DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_x_count    (req_x_count),
      .req_y_count    (req_y_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_heading_q6 (rsp_heading_q6),
      .rsp_zero_field (rsp_zero_field)
   );

   heading_checker u_heading_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_x_count    (req_x_count),
      .req_y_count    (req_y_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_heading_q6 (rsp_heading_q6),
      .rsp_zero_field (rsp_zero_field),
      .mismatches     (mismatches),
      .words_pending  (words_pending),
      .words_checked  (words_checked)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Offer one word and hold it until taken
   task automatic send_sample(input logic signed [IN_W-1:0] x,
                              input logic signed [IN_W-1:0] y);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_x_count <= x;
      req_y_count <= y;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Idle between words; back-to-back through the pressure window and one later stretch
   task automatic sender_gap();
      int r;
      int gap;
      r = $urandom_range(0, 99);
      if ((words_sent >= 380 && words_sent < 720) || (words_sent >= 1300 && words_sent < 1500))
         gap = 0;
      else if (r < 60) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 8);
      else gap = $urandom_range(15, 50);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic logic signed [IN_W-1:0] pick_extreme();
      case ($urandom_range(0, 5))
         0:       return -16'sd32768;
         1:       return -16'sd32767;
         2:       return -16'sd1;
         3:       return 16'sd0;
         4:       return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   // Mix of full-range, tiny, near-axis, extreme and diagonal vectors
   task automatic send_random_sample();
      int r;
      logic signed [IN_W-1:0] x, y, v;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         x = IN_W'($urandom);
         y = IN_W'($urandom);
      end else if (r < 70) begin
         x = IN_W'($urandom_range(0, 16)) - 16'sd8;
         y = IN_W'($urandom_range(0, 16)) - 16'sd8;
      end else if (r < 85) begin
         v = IN_W'($urandom);
         if ($urandom_range(0, 1)) begin
            x = v;
            y = IN_W'($urandom_range(0, 4)) - 16'sd2;
         end else begin
            x = IN_W'($urandom_range(0, 4)) - 16'sd2;
            y = v;
         end
      end else if (r < 93) begin
         x = pick_extreme();
         y = pick_extreme();
      end else begin
         v = IN_W'($urandom);
         x = v;
         y = $urandom_range(0, 1) ? v : -v;
      end
      send_sample(x, y);
   endtask

   // Response side: random stalls, one long hold-off, one stall-free stretch
   initial begin
      bit hold_done;
      int r;
      int n;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && words_sent >= 400) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else if (words_sent >= 900 && words_sent < 1200) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_ready <= 1'b1;
               n = 1;
            end else if (r < 96) begin
               rsp_ready <= 1'b0;
               n = $urandom_range(1, 3);
            end else begin
               rsp_ready <= 1'b0;
               n = $urandom_range(10, 40);
            end
            repeat (n) @(negedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_x_count = '0;
      req_y_count = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // null vector, axes, corners, near north (full-turn wrap), near south
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sd32767, 16'sd0);
      send_sample(-16'sd32768, 16'sd0);
      send_sample(16'sd0, 16'sd32767);
      send_sample(16'sd0, -16'sd32768);
      send_sample(-16'sd32768, -16'sd32768);
      send_sample(16'sd32767, 16'sd32767);
      send_sample(-16'sd32768, 16'sd32767);
      send_sample(16'sd32767, -16'sd32768);
      send_sample(16'sd1, 16'sd0);
      send_sample(-16'sd1, 16'sd0);
      send_sample(16'sd0, 16'sd1);
      send_sample(16'sd0, -16'sd1);
      send_sample(-16'sd1, -16'sd1);
      send_sample(16'sd1, -16'sd1);
      send_sample(16'sd32767, 16'sd1);
      send_sample(16'sd32767, -16'sd1);
      send_sample(16'sd20000, 16'sd3);
      send_sample(-16'sd32768, 16'sd1);
      send_sample(-16'sd32768, -16'sd1);
      send_sample(16'sd1, -16'sd32768);
      send_sample(-16'sd1, 16'sd32767);
      directed_words = words_sent;

      repeat (RANDOM_WORDS) begin
         sender_gap();
         send_random_sample();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (words_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request words (%0d directed), %0d response words checked.",
               words_sent, directed_words, words_checked);
      $display("Included a %0d-cycle response hold-off with back-to-back requests.",
               HOLD_CYCLES);
      if (mismatches == 0 && words_pending == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
